>>> design/lcdn_pkg.sv
// Shared types, constants and the control program of the LCD nibble bus sequencer.
package lcdn_pkg;

    localparam int PC_W    = 5;
    localparam int MAG_W   = 18;
    localparam int DIGITS  = 6;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int PHASE_W = 3;

    localparam logic [2:0] REQ_CMD  = 3'd0;
    localparam logic [2:0] REQ_DATA = 3'd1;
    localparam logic [2:0] REQ_INIT = 3'd2;
    localparam logic [2:0] REQ_NUM5 = 3'd3;
    localparam logic [2:0] REQ_NUM2 = 3'd4;

    localparam logic [9:0] HOLD_NONE_MS  = 10'd0;
    localparam logic [9:0] HOLD_STEP_MS  = 10'd1;
    localparam logic [9:0] HOLD_SHORT_MS = 10'd5;
    localparam logic [9:0] HOLD_LONG_MS  = 10'd20;
    localparam logic [9:0] HOLD_POWER_MS = 10'd1000;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    localparam logic [PHASE_W-1:0] PHASE_TAIL = 3'd4;

    // Entry points of the program
    localparam logic [PC_W-1:0] PC_CMD  = 5'd0;
    localparam logic [PC_W-1:0] PC_DATA = 5'd1;
    localparam logic [PC_W-1:0] PC_INIT = 5'd2;
    localparam logic [PC_W-1:0] PC_NUM5 = 5'd11;
    localparam logic [PC_W-1:0] PC_NUM2 = 5'd19;

    typedef enum logic [2:0] {
        OP_BYTE,
        OP_PAUSE,
        OP_CONV,
        OP_JPOS,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_INPUT,
        SRC_DIGIT
    } src_t;

    typedef struct packed {
        op_t        op;
        src_t       src;
        logic       rs;
        logic [7:0] arg;
        logic [9:0] hold;
        logic       last;
    } ctrl_word_t;

    typedef struct packed {
        logic       pause;
        logic       rs;
        logic [7:0] value;
        logic [9:0] tail;
        logic       last;
    } pin_cmd_t;

    function automatic ctrl_word_t mk_word(input op_t op, input src_t src, input logic rs,
                                           input logic [7:0] arg, input logic [9:0] hold,
                                           input logic last);
        ctrl_word_t w;
        w.op   = op;
        w.src  = src;
        w.rs   = rs;
        w.arg  = arg;
        w.hold = hold;
        w.last = last;
        return w;
    endfunction

    function automatic ctrl_word_t ucode_word(input logic [PC_W-1:0] addr);
        ctrl_word_t w;
        case (addr)
            5'd0:  w = mk_word(OP_BYTE,  SRC_INPUT, 1'b0, 8'h00, HOLD_NONE_MS, 1'b1);
            5'd1:  w = mk_word(OP_BYTE,  SRC_INPUT, 1'b1, 8'h00, HOLD_NONE_MS, 1'b1);
            5'd2:  w = mk_word(OP_PAUSE, SRC_CONST, 1'b0, 8'h00, HOLD_POWER_MS, 1'b0);
            5'd3:  w = mk_word(OP_PAUSE, SRC_CONST, 1'b0, 8'h00, HOLD_POWER_MS, 1'b0);
            5'd4:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h03, HOLD_SHORT_MS, 1'b0);
            5'd5:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h03, HOLD_SHORT_MS, 1'b0);
            5'd6:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h03, HOLD_SHORT_MS, 1'b0);
            5'd7:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h02, HOLD_LONG_MS, 1'b0);
            5'd8:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h0F, HOLD_LONG_MS, 1'b0);
            5'd9:  w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h01, HOLD_LONG_MS, 1'b0);
            5'd10: w = mk_word(OP_BYTE,  SRC_CONST, 1'b0, 8'h06, HOLD_LONG_MS, 1'b1);
            5'd11: w = mk_word(OP_CONV,  SRC_CONST, 1'b0, 8'h00, HOLD_NONE_MS, 1'b0);
            5'd12: w = mk_word(OP_JPOS,  SRC_CONST, 1'b0, 8'd14, HOLD_NONE_MS, 1'b0);
            5'd13: w = mk_word(OP_BYTE,  SRC_CONST, 1'b1, ASCII_MINUS, HOLD_NONE_MS, 1'b0);
            5'd14: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd4, HOLD_NONE_MS, 1'b0);
            5'd15: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd3, HOLD_NONE_MS, 1'b0);
            5'd16: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd2, HOLD_NONE_MS, 1'b0);
            5'd17: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd1, HOLD_NONE_MS, 1'b0);
            5'd18: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd0, HOLD_NONE_MS, 1'b1);
            5'd19: w = mk_word(OP_CONV,  SRC_CONST, 1'b0, 8'h00, HOLD_NONE_MS, 1'b0);
            5'd20: w = mk_word(OP_JPOS,  SRC_CONST, 1'b0, 8'd22, HOLD_NONE_MS, 1'b0);
            5'd21: w = mk_word(OP_BYTE,  SRC_CONST, 1'b1, ASCII_MINUS, HOLD_NONE_MS, 1'b0);
            5'd22: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd1, HOLD_NONE_MS, 1'b0);
            5'd23: w = mk_word(OP_BYTE,  SRC_DIGIT, 1'b1, 8'd0, HOLD_NONE_MS, 1'b1);
            default: w = mk_word(OP_END, SRC_CONST, 1'b0, 8'h00, HOLD_NONE_MS, 1'b1);
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] entry_pc(input logic [2:0] kind);
        logic [PC_W-1:0] pc;
        case (kind)
            REQ_CMD:  pc = PC_CMD;
            REQ_DATA: pc = PC_DATA;
            REQ_INIT: pc = PC_INIT;
            REQ_NUM5: pc = PC_NUM5;
            REQ_NUM2: pc = PC_NUM2;
            default:  pc = PC_CMD;
        endcase
        return pc;
    endfunction

endpackage

>>> design/lcdn_if.sv
// Handshake interfaces for the request and pin event channels.
interface lcdn_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic [7:0]         byte_value;
    logic signed [17:0] number_value;

    modport source (output valid, output req_type, output byte_value,
                    output number_value, input ready);
    modport sink   (input valid, input req_type, input byte_value,
                    input number_value, output ready);
endinterface

interface lcdn_evt_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [9:0] hold_ms;
    logic       last;

    modport source (output valid, output reg_select, output data_nibble,
                    output enable_level, output hold_ms, output last, input ready);
    modport sink   (input valid, input reg_select, input data_nibble,
                    input enable_level, input hold_ms, input last, output ready);
endinterface

>>> design/lcdn_bcd.sv
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
module lcdn_bcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lcdn_pkg::MAG_W-1:0]  mag,
    output logic                        busy,
    output logic [lcdn_pkg::BCD_W-1:0]  digits
);
    import lcdn_pkg::*;

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [MAG_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [BCD_W-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                         : bcd_reg[4*i +: 4];
        end
        busy_next  = busy_reg;
        count_next = count_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(MAG_W);
            bin_next   = mag;
            bcd_next   = '0;
        end
        else if (busy_reg)
        begin
            bcd_next   = {adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next   = {bin_reg[MAG_W-2:0], 1'b0};
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy   = busy_reg;
    assign digits = bcd_reg;

endmodule

>>> design/lcdn_pin_gen.sv
// Expands one byte or pause command into pin events behind an output register.
module lcdn_pin_gen (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lcdn_pkg::pin_cmd_t cmd,
    output logic               evt_valid,
    input  logic               evt_ready,
    output logic               reg_select,
    output logic [3:0]         data_nibble,
    output logic               enable_level,
    output logic [9:0]         hold_ms,
    output logic               last
);
    import lcdn_pkg::*;

    logic               active_reg, active_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    pin_cmd_t           cmd_reg, cmd_next;
    logic               valid_reg, valid_next;
    logic               rs_reg, rs_next;
    logic [3:0]         nib_reg, nib_next;
    logic               en_reg, en_next;
    logic [9:0]         hold_reg, hold_next;
    logic               last_reg, last_next;
    logic               final_event;

    assign cmd_ready   = !active_reg;
    assign final_event = cmd_reg.pause || (phase_reg == PHASE_TAIL);

    always_comb
    begin
        active_next = active_reg;
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        valid_next  = valid_reg;
        rs_next     = rs_reg;
        nib_next    = nib_reg;
        en_next     = en_reg;
        hold_next   = hold_reg;
        last_next   = last_reg;

        if (valid_reg && evt_ready)
        begin
            valid_next = 1'b0;
        end

        if (!active_reg)
        begin
            if (cmd_valid)
            begin
                active_next = 1'b1;
                cmd_next    = cmd;
                phase_next  = '0;
            end
        end
        else if (!valid_reg || evt_ready)
        begin
            valid_next = 1'b1;
            last_next  = final_event && cmd_reg.last;
            if (cmd_reg.pause)
            begin
                rs_next   = 1'b0;
                nib_next  = 4'h0;
                en_next   = 1'b0;
                hold_next = cmd_reg.tail;
            end
            else
            begin
                rs_next   = cmd_reg.rs;
                nib_next  = (phase_reg < PHASE_W'(2)) ? cmd_reg.value[7:4] : cmd_reg.value[3:0];
                en_next   = phase_reg[0];
                hold_next = (phase_reg == PHASE_TAIL) ? cmd_reg.tail : HOLD_STEP_MS;
            end
            if (final_event)
            begin
                active_next = 1'b0;
            end
            else
            begin
                phase_next = phase_reg + PHASE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        rs_reg   <= rs_next;
        nib_reg  <= nib_next;
        en_reg   <= en_next;
        hold_reg <= hold_next;
        last_reg <= last_next;
    end

    assign evt_valid    = valid_reg;
    assign reg_select   = rs_reg;
    assign data_nibble  = nib_reg;
    assign enable_level = en_reg;
    assign hold_ms      = hold_reg;
    assign last         = last_reg;

endmodule

>>> design/lcdn_seq.sv
// Step counter and control program decode; issues pin commands and conversions.
module lcdn_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [2:0]                  req_type,
    input  logic [7:0]                  byte_value,
    input  logic signed [17:0]          number_value,
    output logic                        conv_start,
    output logic [lcdn_pkg::MAG_W-1:0]  conv_mag,
    input  logic                        conv_busy,
    input  logic [lcdn_pkg::BCD_W-1:0]  digits,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output lcdn_pkg::pin_cmd_t          cmd
);
    import lcdn_pkg::*;

    logic             busy_reg, busy_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             conv_go_reg, conv_go_next;
    logic [7:0]       byte_reg, byte_next;
    logic             neg_reg, neg_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    ctrl_word_t       word;
    logic [7:0]       src_byte;
    logic [3:0]       digit;

    assign word  = ucode_word(pc_reg);
    assign digit = digits[{word.arg[2:0], 2'b00} +: 4];

    always_comb
    begin
        case (word.src)
            SRC_CONST: src_byte = word.arg;
            SRC_INPUT: src_byte = byte_reg;
            SRC_DIGIT: src_byte = ASCII_ZERO | {4'h0, digit};
            default:   src_byte = word.arg;
        endcase
    end

    always_comb
    begin
        cmd.pause = (word.op == OP_PAUSE);
        cmd.rs    = word.rs;
        cmd.value = src_byte;
        cmd.tail  = word.hold;
        cmd.last  = word.last;
    end

    always_comb
    begin
        busy_next    = busy_reg;
        pc_next      = pc_reg;
        conv_go_next = conv_go_reg;
        byte_next    = byte_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        cmd_valid    = 1'b0;
        conv_start   = 1'b0;
        req_ready    = !busy_reg;

        if (!busy_reg)
        begin
            if (req_valid)
            begin
                byte_next = byte_value;
                neg_next  = number_value[17];
                mag_next  = number_value[17] ? $unsigned(-number_value)
                                             : $unsigned(number_value);
                // Unknown request kinds are taken and dropped.
                if (req_type <= REQ_NUM2)
                begin
                    busy_next = 1'b1;
                    pc_next   = entry_pc(req_type);
                end
            end
        end
        else
        begin
            case (word.op)
                OP_BYTE, OP_PAUSE:
                begin
                    cmd_valid = 1'b1;
                    if (cmd_ready)
                    begin
                        if (word.last)
                        begin
                            busy_next = 1'b0;
                        end
                        else
                        begin
                            pc_next = pc_reg + PC_W'(1);
                        end
                    end
                end
                OP_CONV:
                begin
                    if (!conv_go_reg)
                    begin
                        conv_start   = 1'b1;
                        conv_go_next = 1'b1;
                    end
                    else if (!conv_busy)
                    begin
                        conv_go_next = 1'b0;
                        pc_next      = pc_reg + PC_W'(1);
                    end
                end
                OP_JPOS:
                begin
                    pc_next = neg_reg ? pc_reg + PC_W'(1) : word.arg[PC_W-1:0];
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            conv_go_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            pc_reg      <= pc_next;
            conv_go_reg <= conv_go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
    end

    assign conv_mag = mag_reg;

endmodule

>>> design/lcd_nibble_bus_sequencer.sv
// Top level of the LCD nibble bus sequencer.
//
// The block turns requests for a character display on a 4-bit bus into a
// stream of pin events. Requests arrive on the req channel (a command byte,
// a data byte, the power-up initialisation, or a signed number printed as
// five or two ASCII digits); pin events leave on the evt channel, each
// carrying the RS level, the DB7..DB4 nibble, the E level and a hold time in
// milliseconds, with last marking the final event of a request.
//
// A short control program held in a constant table sequences each request.
// Every byte becomes five events, one per cycle while the receiver takes
// them; each byte is first handed to the event generator. Numbers first go
// through a bit-serial binary to BCD conversion and a sign test, then print
// up to six bytes. For a byte request, the step counter takes the request
// and hands the byte to the event generator, which then loads the first
// event into the output register.
//
// The next request is accepted once the final byte of the current one has
// been passed to the event generator. When the receiver stalls, the event
// in the output register holds and the program waits at its current step.
// Request kinds five to seven are taken and produce no transactions. Reset
// returns the step counter and the event generator to idle at once.
module lcd_nibble_bus_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    lcdn_req_if.sink    req,
    lcdn_evt_if.source  evt
);
    import lcdn_pkg::*;

    logic             conv_start;
    logic [MAG_W-1:0] conv_mag;
    logic             conv_busy;
    logic [BCD_W-1:0] digits;
    logic             cmd_valid;
    logic             cmd_ready;
    pin_cmd_t         cmd;

    lcdn_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req.valid),
        .req_ready    (req.ready),
        .req_type     (req.req_type),
        .byte_value   (req.byte_value),
        .number_value (req.number_value),
        .conv_start   (conv_start),
        .conv_mag     (conv_mag),
        .conv_busy    (conv_busy),
        .digits       (digits),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // Digit conversion for the number requests.
    lcdn_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (conv_start),
        .mag    (conv_mag),
        .busy   (conv_busy),
        .digits (digits)
    );

    // Event expansion and the output register of the evt channel.
    lcdn_pin_gen u_pin_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .evt_valid    (evt.valid),
        .evt_ready    (evt.ready),
        .reg_select   (evt.reg_select),
        .data_nibble  (evt.data_nibble),
        .enable_level (evt.enable_level),
        .hold_ms      (evt.hold_ms),
        .last         (evt.last)
    );

endmodule

>>> design/lcdn_checker.sv
// Port-level assertions for the LCD nibble bus sequencer and their binding.
module lcdn_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       evt_valid,
    input logic       evt_ready,
    input logic       reg_select,
    input logic [3:0] data_nibble,
    input logic       enable_level,
    input logic [9:0] hold_ms,
    input logic       last
);
    import lcdn_pkg::*;

    // A stalled event keeps its levels.
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && !evt_ready |=> evt_valid && $stable(data_nibble)
        && $stable(enable_level) && $stable(hold_ms) && $stable(last))
        else $error("stalled pin event changed");

    // Every enable pulse lasts one millisecond and never closes a request.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && enable_level |-> hold_ms == HOLD_STEP_MS && !last)
        else $error("enable pulse with wrong hold or final flag");

    // A request always ends with the strobe low.
    a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && last |-> !enable_level)
        else $error("request ended with enable high");

    // The power-up waits drive an idle bus.
    a_power_wait: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid && hold_ms == HOLD_POWER_MS |-> !reg_select && data_nibble == 4'h0
        && !enable_level)
        else $error("power-up wait with active bus");

endmodule

bind lcd_nibble_bus_sequencer lcdn_checker u_lcdn_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_valid    (evt.valid),
    .evt_ready    (evt.ready),
    .reg_select   (evt.reg_select),
    .data_nibble  (evt.data_nibble),
    .enable_level (evt.enable_level),
    .hold_ms      (evt.hold_ms),
    .last         (evt.last)
);

>>> verif/tb.sv
// Self-checking testbench for the LCD nibble bus sequencer.
`timescale 1ns / 100ps

// The bench offers display requests on the request channel and predicts the
// pin events that each accepted request must produce. The predictor covers
// command bytes, data bytes, the power-up initialisation, and five- and
// two-digit signed numbers. Every event transaction that leaves the block is
// compared, field by field, with the oldest prediction still waiting.
//
// Stimulus starts with a short directed list and then moves on to random
// requests. The sender works in bursts with gaps between them. The receiver
// stalls on a pattern that changes from time to time. Once in the run the
// receiver holds off for a long stretch so that the block fills up and
// stalls its input. At chosen points the sender also waits until every
// predicted event has arrived before it offers the next request.
module tb;

    import lcdn_pkg::*;

    // Request kinds five to seven are spare codes and the block drops them.
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    // Power-up command bytes and the wait after each, first command in the top slot.
    localparam logic [55:0] INIT_CMD_BYTES =
        {8'h03, 8'h03, 8'h03, 8'h02, 8'h0F, 8'h01, 8'h06};
    localparam logic [69:0] INIT_CMD_WAITS =
        {HOLD_SHORT_MS, HOLD_SHORT_MS, HOLD_SHORT_MS,
         HOLD_LONG_MS, HOLD_LONG_MS, HOLD_LONG_MS, HOLD_LONG_MS};
    localparam int INIT_CMD_COUNT = 7;

    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_REQUESTS  = 200;
    localparam int FIRST_BATCH      = 60;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int TAIL_CYCLES      = 100;

    typedef struct {
        logic [2:0]         kind;
        logic [7:0]         byte_value;
        logic signed [17:0] number_value;
        bit                 wait_drained;
    } lcd_request_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] data_nibble;
        logic       enable_level;
        logic [9:0] hold_ms;
        logic       last;
    } pin_event_t;

    // How the receiver paces its ready line between mode changes.
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_RARE
    } stall_mode_t;

    logic clk;
    logic rst_n;

    lcdn_req_if req_ch ();
    lcdn_evt_if evt_ch ();

    lcd_nibble_bus_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .evt   (evt_ch.source)
    );

    // Requests waiting to be offered, and pin events predicted but not yet seen.
    lcd_request_t pending_reqs[$];
    pin_event_t   expected_pins[$];

    lcd_request_t offered_req;
    int           error_count;
    int           burst_left;
    int           gap_left;
    int           long_hold_tokens;
    int           long_hold_served;
    int           long_hold_left;
    int           mode_left;
    int           pattern_phase;
    int           idle_cycles;
    stall_mode_t  stall_mode;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction of the pin events.
    // ------------------------------------------------------------------

    task automatic queue_pin_event(input logic rs, input logic [3:0] nibble,
                                   input logic en, input logic [9:0] hold);
        pin_event_t ev;
        ev.reg_select   = rs;
        ev.data_nibble  = nibble;
        ev.enable_level = en;
        ev.hold_ms      = hold;
        ev.last         = 1'b0;
        expected_pins.push_back(ev);
    endtask

    // One byte is the high nibble strobed, then the low nibble strobed, and
    // finally E dropped with the low nibble left on the bus for the tail hold.
    task automatic queue_byte_events(input logic rs, input logic [7:0] value,
                                     input logic [9:0] tail);
        queue_pin_event(rs, value[7:4], 1'b0, HOLD_STEP_MS);
        queue_pin_event(rs, value[7:4], 1'b1, HOLD_STEP_MS);
        queue_pin_event(rs, value[3:0], 1'b0, HOLD_STEP_MS);
        queue_pin_event(rs, value[3:0], 1'b1, HOLD_STEP_MS);
        queue_pin_event(rs, value[3:0], 1'b0, tail);
    endtask

    task automatic predict_pin_events(input lcd_request_t r);
        int         first_new;
        int         value;
        int         magnitude;
        int         divisor;
        pin_event_t tail_ev;
        first_new = expected_pins.size();
        case (r.kind)
            REQ_CMD:  queue_byte_events(1'b0, r.byte_value, HOLD_NONE_MS);
            REQ_DATA: queue_byte_events(1'b1, r.byte_value, HOLD_NONE_MS);
            REQ_INIT:
            begin
                // Two long power-on waits with every pin low, then the commands.
                queue_pin_event(1'b0, 4'h0, 1'b0, HOLD_POWER_MS);
                queue_pin_event(1'b0, 4'h0, 1'b0, HOLD_POWER_MS);
                for (int i = 0; i < INIT_CMD_COUNT; i++)
                begin
                    queue_byte_events(1'b0,
                        INIT_CMD_BYTES[8 * (INIT_CMD_COUNT - 1 - i) +: 8],
                        INIT_CMD_WAITS[10 * (INIT_CMD_COUNT - 1 - i) +: 10]);
                end
            end
            REQ_NUM5, REQ_NUM2:
            begin
                // The most negative value has a magnitude that only fits
                // because the arithmetic here is wider than the field.
                value     = r.number_value;
                magnitude = (value < 0) ? -value : value;
                if (value < 0)
                begin
                    queue_byte_events(1'b1, ASCII_MINUS, HOLD_NONE_MS);
                end
                divisor = (r.kind == REQ_NUM5) ? 10000 : 10;
                while (divisor != 0)
                begin
                    queue_byte_events(1'b1, ASCII_ZERO + 8'((magnitude / divisor) % 10),
                                      HOLD_NONE_MS);
                    divisor = divisor / 10;
                end
            end
            default:
            begin
                // Spare kinds are taken and give nothing.
            end
        endcase
        if (expected_pins.size() > first_new)
        begin
            tail_ev      = expected_pins.pop_back();
            tail_ev.last = 1'b1;
            expected_pins.push_back(tail_ev);
        end
    endtask

    task automatic add_request(input logic [2:0] kind, input logic [7:0] value,
                               input int number, input bit wait_drained);
        lcd_request_t r;
        r.kind         = kind;
        r.byte_value   = value;
        r.number_value = number[17:0];
        r.wait_drained = wait_drained;
        pending_reqs.push_back(r);
    endtask

    task automatic check_pin_field(input string field, input logic [9:0] want,
                                   input logic [9:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver. A request stays on the bus until it is taken; a new
    // one is only put up once the old one has gone, so valid never drops
    // and rises again at the same edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_pin_events(offered_req);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].wait_drained && expected_pins.size() != 0))
                begin
                    // Nothing to send, or the next request waits for the display
                    // stream to run dry first.
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    offered_req = pending_reqs.pop_front();
                    req_ch.valid        <= 1'b1;
                    req_ch.req_type     <= offered_req.kind;
                    req_ch.byte_value   <= offered_req.byte_value;
                    req_ch.number_value <= offered_req.number_value;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing. A long hold-off requested by the stimulus takes
    // priority; otherwise the ready line follows the current stall mode.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            evt_ch.ready <= 1'b0;
        end
        else if (long_hold_left > 0)
        begin
            long_hold_left--;
            evt_ch.ready <= 1'b0;
        end
        else if (long_hold_served != long_hold_tokens)
        begin
            long_hold_served++;
            long_hold_left = LONG_HOLD_CYCLES;
            evt_ch.ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(32, 256);
            end
            else
            begin
                mode_left--;
            end
            pattern_phase++;
            case (stall_mode)
                STALL_NONE:     evt_ch.ready <= 1'b1;
                STALL_COIN:     evt_ch.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: evt_ch.ready <= ((pattern_phase % 5) >= 2);
                default:        evt_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Event monitor: each accepted event transaction is matched against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : pin_monitor
        pin_event_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            if (expected_pins.size() == 0)
            begin
                error_count++;
                $display("%0t: extra pin event, expected none, actual %b %h %b %0d %b",
                         $time, evt_ch.reg_select, evt_ch.data_nibble,
                         evt_ch.enable_level, evt_ch.hold_ms, evt_ch.last);
            end
            else
            begin
                want = expected_pins.pop_front();
                check_pin_field("reg_select", 10'(want.reg_select), 10'(evt_ch.reg_select));
                check_pin_field("data_nibble", 10'(want.data_nibble), 10'(evt_ch.data_nibble));
                check_pin_field("enable_level", 10'(want.enable_level),
                                10'(evt_ch.enable_level));
                check_pin_field("hold_ms", want.hold_ms, evt_ch.hold_ms);
                check_pin_field("last", 10'(want.last), 10'(evt_ch.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: while work is outstanding, some transaction must move on
    // one of the two channels within the limit.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (evt_ch.valid && evt_ch.ready) ||
                (pending_reqs.size() == 0 && !req_ch.valid && expected_pins.size() == 0))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of the run.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int   counted;
        int   pick;
        int   number;
        bit   drain;
        logic [2:0] kind;

        clk                 = 1'b0;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_CMD;
        req_ch.byte_value   = 8'h00;
        req_ch.number_value = 18'sd0;
        evt_ch.ready        = 1'b0;
        error_count         = 0;
        burst_left          = 1;
        gap_left            = 0;
        long_hold_tokens    = 0;
        long_hold_served    = 0;
        long_hold_left      = 0;
        mode_left           = 0;
        pattern_phase       = 0;
        idle_cycles         = 0;
        stall_mode          = STALL_NONE;

        // Directed part: byte extremes, the initialisation, number extremes
        // including the most negative value and values that wrap past the
        // printed digits, and the spare kinds.
        add_request(REQ_CMD,  8'h00, 0, 1'b0);
        add_request(REQ_CMD,  8'hFF, 0, 1'b0);
        add_request(REQ_DATA, 8'h00, 0, 1'b0);
        add_request(REQ_DATA, 8'hFF, 0, 1'b0);
        add_request(REQ_DATA, 8'h5A, 0, 1'b0);
        add_request(REQ_INIT, 8'h00, 0, 1'b1);
        add_request(REQ_NUM5, 8'h00, 0, 1'b0);
        add_request(REQ_NUM5, 8'h00, 99999, 1'b0);
        add_request(REQ_NUM5, 8'h00, 100000, 1'b0);
        add_request(REQ_NUM5, 8'h00, 131071, 1'b0);
        add_request(REQ_NUM5, 8'h00, -131072, 1'b0);
        add_request(REQ_NUM5, 8'h00, -1, 1'b0);
        add_request(REQ_NUM5, 8'h00, -99999, 1'b0);
        add_request(REQ_NUM2, 8'h00, 0, 1'b0);
        add_request(REQ_NUM2, 8'h00, 99, 1'b0);
        add_request(REQ_NUM2, 8'h00, 100, 1'b0);
        add_request(REQ_NUM2, 8'h00, -5, 1'b0);
        add_request(REQ_NUM2, 8'h00, 131071, 1'b0);
        add_request(REQ_NUM2, 8'h00, -131072, 1'b0);
        for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
        begin
            add_request(3'(k), 8'($urandom), int'($urandom), 1'b0);
        end
        add_request(REQ_DATA, 8'h41, 0, 1'b0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Random part. Numbers are mostly drawn over the full field, with a
        // share kept small so that short and zero-padded digit strings appear.
        counted = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (counted == FIRST_BATCH)
            begin
                // Let the first batch run low, then starve the receiver for a
                // long stretch while the sender keeps offering requests.
                while (pending_reqs.size() > 20) @(posedge clk);
                long_hold_tokens <= long_hold_tokens + 1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                kind = REQ_CMD;
            else if (pick < 60)
                kind = REQ_DATA;
            else if (pick < 65)
                kind = REQ_INIT;
            else if (pick < 82)
                kind = REQ_NUM5;
            else if (pick < 97)
                kind = REQ_NUM2;
            else
                kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
            if ($urandom_range(0, 3) == 0)
                number = int'($urandom_range(0, 300)) - 150;
            else
                number = int'($urandom);
            drain = (counted == FIRST_BATCH + 1) || ($urandom_range(0, 39) == 0);
            add_request(kind, 8'($urandom), number, drain);
            if (kind < REQ_SPARE_FIRST)
                counted++;
        end

        // Wait for every request to be taken and every event to arrive, then
        // give the block a while to show any stray events.
        while (pending_reqs.size() != 0 || req_ch.valid || expected_pins.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_pins.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
